// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/sps_pkg.sv
`timescale 1ns / 1ps
package sps_pkg;

  localparam int RETX_DEPTH_DEF    = 16;
  localparam int PENDING_DEPTH_DEF = 16;
  localparam int AVAIL_W           = 5;
  localparam int CFG_IDX_W         = 3;

  typedef enum logic [1:0] {
    REQ_PUBLISH   = 2'd0,
    REQ_QUEUE     = 2'd1,
    REQ_ACK       = 2'd2,
    REQ_REPUBLISH = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_GOOD        = 3'd0,
    ST_NOT_READY   = 3'd1,
    ST_SEQ_UNKNOWN = 3'd2,
    ST_UNAVAILABLE = 3'd3,
    ST_QUEUE_FULL  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUB_NUM    = 3'd0,
    CFG_INTERVAL   = 3'd1,
    CFG_KA_COUNT   = 3'd2,
    CFG_PUB_ENABLE = 3'd3,
    CFG_START      = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC,
    S_CHECK,
    S_POP,
    S_QUEUE,
    S_MISS,
    S_SR_RD,
    S_SR_CMP,
    S_SH_RD,
    S_SH_WR,
    S_STORE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic in_rdy;
    logic calc;
    logic set_nr;
    logic keepalive;
    logic pop;
    logic queue;
    logic srch_next;
    logic hit_rep;
    logic miss;
    logic shift_mode;
    logic shift_wr;
    logic sh_end;
    logic store;
    logic finish;
  } sps_cmd_t;

  typedef struct packed {
    logic  in_valid;
    req_t  in_req;
    req_t  req;
    logic  not_ready;
    logic  data;
    logic  rfull;
    logic  rzero;
    logic  ridx_last;
    logic  match;
    logic  out_free;
  } sps_stat_t;

endpackage

// File: rtl/sps_req_if.sv
`timescale 1ns / 1ps
interface sps_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic [31:0] note_handle;
  logic [31:0] seq_in;
  modport source (output valid, req_type, now_ms, note_handle, seq_in, input ready);
  modport sink (input valid, req_type, now_ms, note_handle, seq_in, output ready);
endinterface

// File: rtl/sps_rsp_if.sv
`timescale 1ns / 1ps
interface sps_rsp_if;
  import sps_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               published;
  logic               keep_alive;
  logic [31:0]        seq_out;
  logic [31:0]        handle_out;
  logic               more_pending;
  logic [AVAIL_W-1:0] available_count;
  logic [31:0]        subscription_out;
  modport source (output valid, status, published, keep_alive, seq_out, handle_out,
                  more_pending, available_count, subscription_out, input ready);
  modport sink (input valid, status, published, keep_alive, seq_out, handle_out,
                more_pending, available_count, subscription_out, output ready);
endinterface

// File: rtl/sps_cfg_if.sv
`timescale 1ns / 1ps
interface sps_cfg_if;
  import sps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/sps_ctrl.sv
`timescale 1ns / 1ps
module sps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  sps_pkg::sps_stat_t st,
  output sps_pkg::sps_cmd_t  cmd
);
  import sps_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (st.in_valid) begin
          unique case (st.in_req)
            REQ_PUBLISH: state_next = S_CALC;
            REQ_QUEUE:   state_next = S_QUEUE;
            default:     state_next = st.rzero ? S_MISS : S_SR_RD;
          endcase
        end
      end
      S_CALC:  state_next = S_CHECK;
      S_CHECK: state_next = (st.not_ready || !st.data) ? S_DONE : S_POP;
      S_POP:   state_next = st.rfull ? S_SH_RD : S_STORE;
      S_QUEUE: state_next = S_DONE;
      S_MISS:  state_next = S_DONE;
      S_SR_RD: state_next = S_SR_CMP;
      S_SR_CMP: begin
        if (st.match) begin
          state_next = (st.req == REQ_ACK) ? S_SH_RD : S_DONE;
        end else begin
          state_next = st.ridx_last ? S_DONE : S_SR_RD;
        end
      end
      S_SH_RD: begin
        if (st.ridx_last) begin
          state_next = (st.req == REQ_PUBLISH) ? S_STORE : S_DONE;
        end else begin
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: state_next = S_SH_RD;
      S_STORE: state_next = S_DONE;
      S_DONE:  state_next = st.out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.in_rdy = 1'b1;
      S_CALC:  cmd.calc = 1'b1;
      S_CHECK: begin
        cmd.set_nr    = st.not_ready;
        cmd.keepalive = !st.not_ready && !st.data;
      end
      S_POP:   cmd.pop = 1'b1;
      S_QUEUE: cmd.queue = 1'b1;
      S_MISS:  cmd.miss = 1'b1;
      S_SR_RD: ;
      S_SR_CMP: begin
        cmd.hit_rep   = st.match && (st.req == REQ_REPUBLISH);
        cmd.miss      = !st.match && st.ridx_last;
        cmd.srch_next = !st.match && !st.ridx_last;
      end
      S_SH_RD: begin
        cmd.shift_mode = 1'b1;
        cmd.sh_end     = st.ridx_last;
      end
      S_SH_WR: begin
        cmd.shift_mode = 1'b1;
        cmd.shift_wr   = 1'b1;
      end
      S_STORE: cmd.store = 1'b1;
      S_DONE:  cmd.finish = st.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/sps_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sps_dp #(
  parameter int RETX_DEPTH    = sps_pkg::RETX_DEPTH_DEF,
  parameter int PENDING_DEPTH = sps_pkg::PENDING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  sps_req_if.sink            req,
  sps_rsp_if.source          rsp,
  sps_cfg_if.sink            cfg,
  input  sps_pkg::sps_cmd_t  cmd,
  output sps_pkg::sps_stat_t st
);
  import sps_pkg::*;

  localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int RW  = (RETX_DEPTH > 1) ? $clog2(RETX_DEPTH) : 1;
  localparam int RCW = $clog2(RETX_DEPTH + 1);

  // configuration
  logic [31:0] sub_num;
  logic [15:0] interval;
  logic [15:0] ka_count;
  logic        pub_enable;

  // request capture
  req_t        req_r;
  logic [31:0] now_r;
  logic [31:0] handle_r;
  logic [31:0] seq_r;

  // subscription state
  logic [31:0] last_time;
  logic        first_sent;
  logic [31:0] next_seq;
  logic [31:0] elapsed_r;
  logic [31:0] wait_r;

  // pending queue
  logic [31:0]    pend_mem [PENDING_DEPTH];
  logic [31:0]    pend_rdata;
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [PCW-1:0] pcount;

  // retransmit store, compacted oldest first
  logic [63:0]    retx_mem [RETX_DEPTH];
  logic [63:0]    retx_rdata;
  logic [RCW-1:0] rcount;
  logic [RCW-1:0] ridx;
  logic [RCW-1:0] raddr;

  // result being built
  status_t     res_status;
  logic        res_pub;
  logic        res_keep;
  logic [31:0] res_seq;
  logic [31:0] res_handle;
  logic        res_more;

  logic        out_valid;
  logic        accept;
  logic [15:0] iv;
  logic [15:0] kc;
  logic [31:0] ka_wait;
  logic        pfull;
  logic [31:0] rcount_ext;

  assign accept    = req.valid && cmd.in_rdy && !rst;
  assign req.ready = cmd.in_rdy && !rst;
  assign cfg.ready = !rst;

  assign iv      = (interval == '0) ? 16'd1 : interval;
  assign kc      = (ka_count == '0) ? 16'd3 : ka_count;
  assign ka_wait = 32'(iv) * 32'(kc);
  assign pfull   = (pcount == PCW'(PENDING_DEPTH));
  assign raddr   = cmd.shift_mode ? (ridx + RCW'(1)) : ridx;
  assign rcount_ext = 32'(rcount);

  assign st.in_valid  = req.valid;
  assign st.in_req    = req_t'(req.req_type);
  assign st.req       = req_r;
  assign st.not_ready = (elapsed_r < wait_r);
  assign st.data      = pub_enable && (pcount != '0);
  assign st.rfull     = (rcount == RCW'(RETX_DEPTH));
  assign st.rzero     = (rcount == '0);
  assign st.ridx_last = ({1'b0, ridx} + (RCW+1)'(1)) >= {1'b0, rcount};
  assign st.match     = (retx_rdata[63:32] == seq_r);
  assign st.out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_num    <= '0;
      interval   <= 16'd1000;
      ka_count   <= 16'd3;
      pub_enable <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_SUB_NUM:    sub_num    <= cfg.data;
        CFG_INTERVAL:   interval   <= cfg.data[15:0];
        CFG_KA_COUNT:   ka_count   <= cfg.data[15:0];
        CFG_PUB_ENABLE: pub_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= req_t'(req.req_type);
      now_r    <= req.now_ms;
      handle_r <= req.note_handle;
      seq_r    <= req.seq_in;
    end
    if (cmd.calc) begin
      elapsed_r <= now_r - last_time;
      wait_r    <= (!first_sent || st.data) ? {16'd0, iv} : ka_wait;
    end
  end

  // timing and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      first_sent <= 1'b0;
      next_seq   <= 32'd1;
    end else begin
      if (cfg.valid && (cfg_idx_t'(cfg.index) == CFG_START)) begin
        last_time <= cfg.data;
      end
      if (cmd.keepalive || cmd.pop) begin
        last_time  <= now_r;
        first_sent <= 1'b1;
      end
      if (cmd.pop) begin
        next_seq <= (next_seq == '1) ? 32'd1 : next_seq + 32'd1;
      end
    end
  end

  // pending queue
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      pcount <= '0;
    end else begin
      if (cmd.queue && !pfull) begin
        tail   <= (tail == PW'(PENDING_DEPTH - 1)) ? '0 : tail + PW'(1);
        pcount <= pcount + PCW'(1);
      end
      if (cmd.pop) begin
        head   <= (head == PW'(PENDING_DEPTH - 1)) ? '0 : head + PW'(1);
        pcount <= pcount - PCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.queue && !pfull) begin
      pend_mem[tail] <= handle_r;
    end
    pend_rdata <= pend_mem[head];
  end

  // retransmit store
  always_ff @(posedge clk) begin
    if (cmd.shift_wr) begin
      retx_mem[ridx[RW-1:0]] <= retx_rdata;
    end else if (cmd.store) begin
      retx_mem[rcount[RW-1:0]] <= {res_seq, res_handle};
    end
    retx_rdata <= retx_mem[raddr[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcount <= '0;
      ridx   <= '0;
    end else begin
      if (accept || cmd.pop) begin
        ridx <= '0;
      end else if (cmd.srch_next || cmd.shift_wr) begin
        ridx <= ridx + RCW'(1);
      end
      if (cmd.sh_end) begin
        rcount <= rcount - RCW'(1);
      end else if (cmd.store) begin
        rcount <= rcount + RCW'(1);
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= ST_GOOD;
      res_pub    <= 1'b0;
      res_keep   <= 1'b0;
      res_seq    <= '0;
      res_handle <= '0;
      res_more   <= 1'b0;
    end else begin
      if (cmd.set_nr) begin
        res_status <= ST_NOT_READY;
      end
      if (cmd.queue && pfull) begin
        res_status <= ST_QUEUE_FULL;
      end
      if (cmd.miss) begin
        res_status <= (req_r == REQ_ACK) ? ST_SEQ_UNKNOWN : ST_UNAVAILABLE;
      end
      if (cmd.keepalive) begin
        res_pub  <= 1'b1;
        res_keep <= 1'b1;
        res_seq  <= next_seq;
      end
      if (cmd.pop) begin
        res_pub    <= 1'b1;
        res_seq    <= next_seq;
        res_handle <= pend_rdata;
        res_more   <= (pcount > PCW'(1));
      end
      if (cmd.hit_rep) begin
        res_seq    <= seq_r;
        res_handle <= retx_rdata[31:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status           <= res_status;
      rsp.published        <= res_pub;
      rsp.keep_alive       <= res_keep;
      rsp.seq_out          <= res_seq;
      rsp.handle_out       <= res_handle;
      rsp.more_pending     <= res_more;
      rsp.available_count  <= rcount_ext[AVAIL_W-1:0];
      rsp.subscription_out <= sub_num;
    end
  end

  assign rsp.valid = out_valid;

  `ASSERT_NOW(a_pcount_bound, 1'b1, pcount <= PCW'(PENDING_DEPTH))
  `ASSERT_NOW(a_store_room, cmd.store, rcount < RCW'(RETX_DEPTH))
  `ASSERT_NEXT(a_finish_shown, cmd.finish, out_valid)

endmodule

// File: rtl/subscription_publish_scheduler.sv
`timescale 1ns / 1ps
// Channel | Dir  | Carries
// req     | in   | req_type, now_ms, note_handle, seq_in
// rsp     | out  | status, published, keep_alive, seq_out, handle_out,
//         |      | more_pending, available_count, subscription_out
// cfg     | in   | index, data (ready outside reset)
// One request in flight; a finished result waits in the output register
// while the next request is taken. Publish: calculate and check, then done
// if not ready or keep-alive; a data publish pops the queue, moves the
// retransmit store down when it is full (its oldest entry goes), stores
// and is done. Queue: queue, then done. Acknowledge/republish compares
// each entry in turn (miss if empty); an ack hit moves later entries down.
// A stalled rsp holds the block in its last state. Synchronous reset, no
// clearing pass; req and cfg are not ready during reset.
module subscription_publish_scheduler #(
  parameter int RETX_DEPTH    = sps_pkg::RETX_DEPTH_DEF,
  parameter int PENDING_DEPTH = sps_pkg::PENDING_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  sps_req_if.sink   req,
  sps_rsp_if.source rsp,
  sps_cfg_if.sink   cfg
);
  import sps_pkg::*;

  sps_cmd_t  cmd;
  sps_stat_t st;

  sps_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  sps_dp #(
    .RETX_DEPTH    (RETX_DEPTH),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .st  (st)
  );

endmodule
